[src/ctms_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ctms_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int LENGTH_BITS = 9;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_value;
        logic                          row_end;
    } t_sample_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] closest_value;
        logic [LENGTH_BITS-1:0]        row_length;
        logic                          overflow_flag;
    } t_result_item;

endpackage

`default_nettype wire

[src/ctms_stream_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface ctms_sample_if import ctms_pkg::*; ();
    logic         valid;
    logic         ready;
    t_sample_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ctms_result_if import ctms_pkg::*; ();
    logic         valid;
    logic         ready;
    t_result_item payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[src/closest_to_mean_select.sv]
// Loads a row of signed samples, one transaction per cycle, into an on-chip buffer of
// MAX_ROW entries while keeping a running sum; the sample flagged row_end closes the row.
// The block then stops taking samples, divides the sum by the element count with a
// restoring divider (one quotient bit per cycle), rounds the mean toward zero, and scans
// the buffer through its single read port, one element per cycle, for the element nearest
// the mean (earliest wins a tie). The result sits in an output register; samples of the
// next row are taken while it waits. Samples arriving with the buffer full are dropped and
// reported through overflow_flag; row_length carries the low 9 bits of the kept count.
`timescale 1ns / 1ps
`default_nettype none

module closest_to_mean_select
    import ctms_pkg::*;
#(
    parameter int MAX_ROW    = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    ctms_sample_if.sink   i_sample,
    ctms_result_if.source o_result
);

    localparam int W   = (VALUE_BITS < SAMPLE_BITS) ? VALUE_BITS : SAMPLE_BITS;
    localparam int AW  = (MAX_ROW > 1) ? $clog2(MAX_ROW) : 1;
    localparam int CW  = $clog2(MAX_ROW + 1);
    localparam int SB  = W + CW;
    localparam int STW = $clog2(SB + 1);

    typedef enum logic [5:0] {
        ST_LOAD = 6'b000001,
        ST_PREP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MEAN = 6'b001000,
        ST_SCAN = 6'b010000,
        ST_DONE = 6'b100000
    } t_state;

    t_state               r_state, n_state;
    logic [CW-1:0]        r_count;
    logic signed [SB-1:0] r_sum;
    logic                 r_dropped;

    logic [SB-1:0]        r_quo;
    logic [CW-1:0]        r_rem;
    logic                 r_neg;
    logic [STW-1:0]       r_step;
    logic signed [W:0]    r_mean;

    logic [CW-1:0]        r_idx;
    logic                 r_pend;
    logic                 r_first;
    logic signed [W-1:0]  r_rd_data;
    logic signed [W-1:0]  r_best;
    logic [W:0]           r_best_dist;

    logic                 r_out_valid;
    t_result_item         r_out;

    logic signed [W-1:0]  mem [MAX_ROW];

    logic                 w_accept;
    logic signed [W-1:0]  w_in_val;
    logic                 w_room;
    logic [SB-1:0]        w_sum_mag;
    logic [CW:0]          w_shifted;
    logic [CW:0]          w_trial;
    logic                 w_rd_en;
    logic signed [W+1:0]  w_diff;
    logic [W:0]           w_dist;
    logic                 w_out_free;

    assign w_accept   = i_sample.valid && i_sample.ready;
    assign w_in_val   = signed'(i_sample.payload.sample_value[W-1:0]);
    assign w_room     = (r_count < CW'(MAX_ROW));
    assign w_sum_mag  = r_sum[SB-1] ? SB'(-r_sum) : SB'(r_sum);
    assign w_shifted  = {r_rem, r_quo[SB-1]};
    assign w_trial    = w_shifted - {1'b0, r_count};
    assign w_rd_en    = (r_state == ST_SCAN) && (r_idx < r_count);
    assign w_diff     = (W+2)'(r_rd_data) - (W+2)'(r_mean);
    assign w_dist     = w_diff[W+1] ? (W+1)'(-w_diff) : (W+1)'(w_diff);
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_sample.ready   = (r_state == ST_LOAD);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_accept && i_sample.payload.row_end) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: n_state = ST_DIV;
            ST_DIV: begin
                if (r_step == STW'(SB - 1)) begin
                    n_state = ST_MEAN;
                end
            end
            ST_MEAN: n_state = ST_SCAN;
            ST_SCAN: begin
                if (!w_rd_en && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // buffer: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_accept && w_room) begin
            mem[r_count[AW-1:0]] <= w_in_val;
        end
        if (w_rd_en) begin
            r_rd_data <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_sum       <= '0;
            r_dropped   <= 1'b0;
            r_step      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_LOAD: begin
                    if (w_accept) begin
                        if (w_room) begin
                            r_count <= r_count + 1'b1;
                            r_sum   <= r_sum + SB'(w_in_val);
                        end else begin
                            r_dropped <= 1'b1;
                        end
                    end
                end
                ST_PREP: begin
                    r_step <= '0;
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                end
                ST_MEAN: begin
                    r_idx   <= '0;
                    r_pend  <= 1'b0;
                    r_first <= 1'b1;
                end
                ST_SCAN: begin
                    r_pend <= w_rd_en;
                    if (w_rd_en) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_pend) begin
                        r_first <= 1'b0;
                    end
                end
                ST_DONE: begin
                    if (w_out_free) begin
                        r_count     <= '0;
                        r_sum       <= '0;
                        r_dropped   <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath: divider, mean, compare and result payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_PREP: begin
                r_quo <= w_sum_mag;
                r_rem <= '0;
                r_neg <= r_sum[SB-1];
            end
            ST_DIV: begin
                if (!w_trial[CW]) begin
                    r_rem <= w_trial[CW-1:0];
                end else begin
                    r_rem <= w_shifted[CW-1:0];
                end
                r_quo <= {r_quo[SB-2:0], !w_trial[CW]};
            end
            ST_MEAN: begin
                r_mean <= r_neg ? signed'(-r_quo[W:0]) : signed'(r_quo[W:0]);
            end
            ST_SCAN: begin
                // strict compare keeps the earliest element on a tie
                if (r_pend && (r_first || (w_dist < r_best_dist))) begin
                    r_best      <= r_rd_data;
                    r_best_dist <= w_dist;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    r_out.closest_value <= SAMPLE_BITS'(r_best);
                    r_out.row_length    <= LENGTH_BITS'(r_count);
                    r_out.overflow_flag <= r_dropped;
                end
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

[bench/ctms_checker.sv]
`timescale 1ns / 1ps

module ctms_checker
    import ctms_pkg::*;
#(
    parameter int MAX_ROW = 256
) (
    input  wire    i_clk,
    input  wire    i_rst_n,
    ctms_sample_if i_sample,
    ctms_result_if i_result,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_rows_closed,
    output int     o_overflow_rows
);

    logic signed [SAMPLE_BITS-1:0] row_store [MAX_ROW];
    int                            kept_count;
    longint                        row_sum;
    logic                          dropped;
    t_result_item                  expected_closest [$];

    // Mean truncates toward zero; strict less-than keeps the earliest on a tie.
    function automatic t_result_item nearest_to_mean();
        longint       mean;
        longint       best_dist;
        longint       cand_dist;
        t_result_item res;
        mean = row_sum / longint'(kept_count);
        res.closest_value = row_store[0];
        best_dist = longint'(row_store[0]) - mean;
        if (best_dist < 0) best_dist = -best_dist;
        for (int k = 1; k < kept_count; k++) begin
            cand_dist = longint'(row_store[k]) - mean;
            if (cand_dist < 0) cand_dist = -cand_dist;
            if (cand_dist < best_dist) begin
                best_dist = cand_dist;
                res.closest_value = row_store[k];
            end
        end
        res.row_length = LENGTH_BITS'(kept_count);
        res.overflow_flag = dropped;
        return res;
    endfunction

    task automatic absorb_sample(input t_sample_item item);
        logic signed [SAMPLE_BITS-1:0] value;
        value = item.sample_value;
        if (kept_count < MAX_ROW) begin
            row_store[kept_count] = value;
            kept_count++;
            row_sum += longint'(value);
        end else begin
            dropped = 1'b1;
        end
        if (item.row_end) begin
            expected_closest.push_back(nearest_to_mean());
            o_rows_closed++;
            if (dropped) o_overflow_rows++;
            kept_count = 0;
            row_sum = 0;
            dropped = 1'b0;
        end
    endtask

    task automatic compare_result(input t_result_item got);
        t_result_item want;
        if (expected_closest.size() == 0) begin
            $display("%0t: unexpected result value %0d length %0d overflow %0b",
                     $time, got.closest_value, got.row_length, got.overflow_flag);
            o_fail_count++;
            return;
        end
        want = expected_closest.pop_front();
        if (got.closest_value !== want.closest_value) begin
            $display("%0t: closest_value expected %0d got %0d",
                     $time, want.closest_value, got.closest_value);
            o_fail_count++;
        end
        if (got.row_length !== want.row_length) begin
            $display("%0t: row_length expected %0d got %0d",
                     $time, want.row_length, got.row_length);
            o_fail_count++;
        end
        if (got.overflow_flag !== want.overflow_flag) begin
            $display("%0t: overflow_flag expected %0b got %0b",
                     $time, want.overflow_flag, got.overflow_flag);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            kept_count = 0;
            row_sum = 0;
            dropped = 1'b0;
            expected_closest.delete();
            o_fail_count = 0;
            o_rows_closed = 0;
            o_overflow_rows = 0;
        end else begin
            if (i_sample.valid && i_sample.ready) absorb_sample(i_sample.payload);
            if (i_result.valid && i_result.ready) compare_result(i_result.payload);
        end
        o_pending = expected_closest.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import ctms_pkg::*;

    localparam int ROW_DEPTH      = 256;
    localparam int ITEM_TARGET    = 1800;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int DRAIN_CYCLES   = 400;
    localparam int DIRECTED_COUNT = 25;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY} t_stall_mode;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ctms_sample_if sample_bus ();
    ctms_result_if result_bus ();

    int fail_count;
    int pending;
    int rows_closed;
    int overflow_rows;

    int          samples_sent = 0;
    int          burst_left   = 0;
    int          cycle_count  = 0;
    t_stall_mode stall_mode   = STALL_NONE;
    int          stall_left   = 0;

    // Single rows at the extremes, truncation of negative means, ties, sums past 32 bits.
    logic signed [SAMPLE_BITS-1:0] directed_values [DIRECTED_COUNT] = '{
        32'sh7FFFFFFF,
        32'sh80000000,
        32'sh80000000, 32'sh7FFFFFFF,
        -32'sd3, 32'sd3,
        -32'sd1, -32'sd2,
        32'sd5, 32'sd5, 32'sd5,
        32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
        32'sd1, 32'sd2, 32'sd3, 32'sd4,
        -32'sd1, -32'sd2, -32'sd3, -32'sd4,
        32'sd0, 32'sd1, -32'sd1
    };
    logic directed_ends [DIRECTED_COUNT] = '{
        1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1,
        1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1
    };

    closest_to_mean_select #(
        .MAX_ROW    (ROW_DEPTH),
        .VALUE_BITS (SAMPLE_BITS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_bus),
        .o_result (result_bus)
    );

    ctms_checker #(
        .MAX_ROW (ROW_DEPTH)
    ) u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_sample        (sample_bus),
        .i_result        (result_bus),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_rows_closed   (rows_closed),
        .o_overflow_rows (overflow_rows)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Result side: alternate between always ready, light and heavy stalling.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 2));
            stall_left = $urandom_range(40, 300);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            STALL_NONE:  result_bus.ready <= 1'b1;
            STALL_LIGHT: result_bus.ready <= ($urandom_range(0, 3) != 0);
            default:     result_bus.ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    function automatic logic signed [SAMPLE_BITS-1:0] pick_value(
        input logic                          clustered,
        input logic signed [SAMPLE_BITS-1:0] center
    );
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (clustered && roll < 8) return center + $urandom_range(0, 8) - 4;
        case (roll)
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2, 3:    return $urandom_range(0, 32) - 16;
            default: return $urandom;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(
        input logic signed [SAMPLE_BITS-1:0] value,
        input logic                          last
    );
        t_sample_item item;
        int           gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                sample_bus.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 16);
        end
        item.sample_value = value;
        item.row_end = last;
        sample_bus.valid <= 1'b1;
        sample_bus.payload <= item;
        do @(posedge i_clk); while (!sample_bus.ready);
        @(negedge i_clk);
        burst_left--;
        samples_sent++;
    endtask

    task automatic send_row(input int len);
        logic                          clustered;
        logic signed [SAMPLE_BITS-1:0] center;
        clustered = 1'($urandom_range(0, 1));
        center = $urandom;
        for (int k = 0; k < len; k++) send_sample(pick_value(clustered, center), k == len - 1);
    endtask

    // Hold off the sample side until every closed row has reported.
    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        burst_left = 0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    initial begin
        int row_idx;
        int len;
        sample_bus.valid = 1'b0;
        sample_bus.payload = '0;
        result_bus.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_COUNT; k++) send_sample(directed_values[k], directed_ends[k]);
        wait_drained();

        // Mostly short rows; a full row, one closing on a full buffer, one well past it.
        row_idx = 0;
        while (samples_sent < ITEM_TARGET) begin
            if (row_idx == 10) len = ROW_DEPTH;
            else if (row_idx == 30) len = ROW_DEPTH + 1;
            else if (row_idx == 45) len = ROW_DEPTH + $urandom_range(2, 40);
            else if ($urandom_range(0, 4) == 0) len = $urandom_range(17, 64);
            else len = $urandom_range(1, 16);
            send_row(len);
            row_idx++;
            if (row_idx == 50) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("sent %0d samples in %0d rows, %0d rows checked", samples_sent,
                 row_idx + 10, rows_closed);
        $display("%0d rows closed with dropped samples", overflow_rows);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
